>>> sv/tafbu_pkg.sv
// shared types and codes for the thumb alu / flags / branch unit
// no dependencies; used by the channel interfaces and the top level
package tafbu_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned OffsetW = 24;
  localparam int unsigned AmtW    = 8;
  localparam logic [WordW-1:0] PcStep = WordW'(2);

  typedef enum logic [4:0] {
    ACT_ADC  = 5'd0,
    ACT_ADD  = 5'd1,
    ACT_EOR  = 5'd2,
    ACT_ORR  = 5'd3,
    ACT_AND  = 5'd4,
    ACT_MOV  = 5'd5,
    ACT_SUB  = 5'd6,
    ACT_CMP  = 5'd7,
    ACT_CMN  = 5'd8,
    ACT_MUL  = 5'd9,
    ACT_TST  = 5'd10,
    ACT_LSL  = 5'd11,
    ACT_LSR  = 5'd12,
    ACT_ROR  = 5'd13,
    ACT_ASR  = 5'd14,
    ACT_REV  = 5'd15,
    ACT_BIC  = 5'd16,
    ACT_MVN  = 5'd17,
    ACT_NEG  = 5'd18,
    ACT_SBC  = 5'd19,
    ACT_NOP  = 5'd20,
    ACT_B    = 5'd21,
    ACT_BL   = 5'd22,
    ACT_BX   = 5'd23
  } action_e;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_CS = 4'd2,
    COND_CC = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13,
    COND_AL = 4'd14
  } cond_e;

  typedef struct packed {
    logic [4:0]                action;
    logic [WordW-1:0]          operand_a;
    logic [WordW-1:0]          operand_b;
    logic [3:0]                branch_cond;
    logic signed [OffsetW-1:0] branch_offset;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] result;
    logic             writes_result;
    logic             flag_negative;
    logic             flag_zero;
    logic             flag_carry;
    logic             flag_overflow;
    logic [WordW-1:0] next_pc;
    logic [WordW-1:0] link_value;
  } out_item_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } nzcv_t;

endpackage

>>> sv/tafbu_if.sv
// valid/ready channel interfaces for instruction beats and result beats
// depends on tafbu_pkg for the payload types
interface tafbu_in_if;
  logic                valid;
  logic                ready;
  tafbu_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tafbu_out_if;
  logic                 valid;
  logic                 ready;
  tafbu_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/thumb_alu_flags_branch_unit.sv
// thumb execute stage: alu with nzcv flags, pc and link register, branches
// depends on tafbu_pkg and the channel interfaces in tafbu_if.sv
//
// Usage:
//   in_i carries one instruction per beat (action, operands, branch condition
//   and halfword offset). out_o carries one result beat per instruction: the
//   destination value, its write enable, the flags, the new pc and the link
//   register, all as they stand after that instruction.
//   An input beat passes through an input register, then one pass of alu /
//   branch logic into the result register. The flags, pc and link register
//   update in that same pass, so the next instruction sees them, and the unit
//   sustains one beat per cycle while out_o does not stall.
//   The longest path is the 32x32 multiplier feeding the zero detect.
//   When out_o stalls, the result register holds and the input register
//   holds its beat; in_i.ready drops only once both are full.
//   Reset clears flags, pc and link register to zero and empties both
//   registers; the unit accepts beats as soon as reset is released.
module thumb_alu_flags_branch_unit (
  input  logic clk_i,
  input  logic rst_ni,
  tafbu_in_if.sink    in_i,
  tafbu_out_if.source out_o
);
  import tafbu_pkg::*;

  in_item_t         item_q;
  logic             item_vld_q;
  out_item_t        res_q, res_d;
  logic             res_vld_q;
  nzcv_t            flags_q, flags_d;
  logic [WordW-1:0] pc_q, pc_d;
  logic [WordW-1:0] lr_q, lr_d;
  logic             advance;

  // result register frees up when empty or taken this cycle
  assign advance    = !res_vld_q || out_o.ready;
  assign in_i.ready = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= in_i.payload;
    end
  end

  // datapath
  logic [WordW-1:0] a, b;
  logic [AmtW-1:0]  amt;
  logic [WordW-1:0] add_x, add_y;
  logic             add_cin;
  logic [WordW:0]   add_sum;
  logic             add_v;
  logic [WordW-1:0] mul_r;
  logic [WordW:0]   lsl_ext, lsr_ext;
  logic signed [WordW:0] asr_ext;
  logic [2*WordW-1:0] ror_ext;
  logic [WordW-1:0] ror_r;
  logic [WordW-1:0] rev_r;
  logic [WordW-1:0] off_step;
  logic             taken;
  logic [WordW-1:0] r;
  logic             wr;
  logic             set_nz, set_cv, set_c;
  logic             c_new;

  assign a   = item_q.operand_a;
  assign b   = item_q.operand_b;
  assign amt = b[AmtW-1:0];

  always_comb begin
    add_x   = a;
    add_y   = b;
    add_cin = 1'b0;
    case (action_e'(item_q.action))
      ACT_ADC: add_cin = flags_q.c;
      ACT_SUB, ACT_CMP: begin
        add_y   = ~b;
        add_cin = 1'b1;
      end
      ACT_SBC: begin
        add_y   = ~b;
        add_cin = flags_q.c;
      end
      ACT_NEG: begin
        add_x   = '0;
        add_y   = ~a;
        add_cin = 1'b1;
      end
      default: ;
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{WordW{1'b0}}, add_cin};
  assign add_v   = ~(add_x[WordW-1] ^ add_y[WordW-1])
                   & (add_x[WordW-1] ^ add_sum[WordW-1]);

  assign mul_r   = a * b;
  // shift out bit lands in the extra position of the lsl, lsr and asr extended words
  assign lsl_ext = {1'b0, a} << amt;
  assign lsr_ext = {a, 1'b0} >> amt;
  assign asr_ext = $signed({a, 1'b0}) >>> amt;
  assign ror_ext = {a, a} >> amt[4:0];
  assign ror_r   = ror_ext[WordW-1:0];
  assign rev_r   = {a[7:0], a[15:8], a[23:16], a[31:24]};
  assign off_step = {{(WordW-OffsetW-1){item_q.branch_offset[OffsetW-1]}},
                     item_q.branch_offset, 1'b0};

  always_comb begin
    case (cond_e'(item_q.branch_cond))
      COND_EQ: taken = flags_q.z;
      COND_NE: taken = !flags_q.z;
      COND_CS: taken = flags_q.c;
      COND_CC: taken = !flags_q.c;
      COND_MI: taken = flags_q.n;
      COND_PL: taken = !flags_q.n;
      COND_VS: taken = flags_q.v;
      COND_VC: taken = !flags_q.v;
      COND_HI: taken = flags_q.c && !flags_q.z;
      COND_LS: taken = !flags_q.c || flags_q.z;
      COND_GE: taken = flags_q.n == flags_q.v;
      COND_LT: taken = flags_q.n != flags_q.v;
      COND_GT: taken = !flags_q.z && (flags_q.n == flags_q.v);
      COND_LE: taken = flags_q.z || (flags_q.n != flags_q.v);
      COND_AL: taken = 1'b1;
      default: taken = 1'b0;
    endcase
  end

  always_comb begin
    r      = '0;
    wr     = 1'b1;
    set_nz = 1'b1;
    set_cv = 1'b0;
    set_c  = 1'b0;
    c_new  = flags_q.c;
    pc_d   = pc_q + PcStep;
    lr_d   = lr_q;
    case (action_e'(item_q.action))
      ACT_ADC, ACT_ADD, ACT_SUB, ACT_NEG, ACT_SBC: begin
        r      = add_sum[WordW-1:0];
        set_cv = 1'b1;
      end
      ACT_CMP, ACT_CMN: begin
        r      = add_sum[WordW-1:0];
        set_cv = 1'b1;
        wr     = 1'b0;
      end
      ACT_EOR: r = a ^ b;
      ACT_ORR: r = a | b;
      ACT_AND: r = a & b;
      ACT_MOV: r = a;
      ACT_MUL: r = mul_r;
      ACT_TST: begin
        r  = a & b;
        wr = 1'b0;
      end
      ACT_LSL: begin
        r     = (amt == '0) ? a : lsl_ext[WordW-1:0];
        set_c = (amt != '0);
        c_new = lsl_ext[WordW];
      end
      ACT_LSR: begin
        r     = (amt == '0) ? a : lsr_ext[WordW:1];
        set_c = (amt != '0);
        c_new = lsr_ext[0];
      end
      ACT_ASR: begin
        r     = (amt == '0) ? a : asr_ext[WordW:1];
        set_c = (amt != '0);
        c_new = asr_ext[0];
      end
      ACT_ROR: begin
        r     = ror_r;
        set_c = (amt != '0);
        c_new = ror_r[WordW-1];
      end
      ACT_REV: begin
        r      = rev_r;
        set_nz = 1'b0;
      end
      ACT_BIC: r = a & ~b;
      ACT_MVN: r = ~a;
      ACT_B: begin
        wr     = 1'b0;
        set_nz = 1'b0;
        if (taken) begin
          pc_d = pc_q + off_step;
        end
      end
      ACT_BL: begin
        wr     = 1'b0;
        set_nz = 1'b0;
        lr_d   = pc_q + PcStep;
        pc_d   = pc_q + off_step;
      end
      ACT_BX: begin
        wr     = 1'b0;
        set_nz = 1'b0;
        pc_d   = a;
      end
      default: begin
        wr     = 1'b0;
        set_nz = 1'b0;
      end
    endcase
  end

  always_comb begin
    flags_d = flags_q;
    if (set_nz) begin
      flags_d.n = r[WordW-1];
      flags_d.z = (r == '0);
    end
    if (set_cv) begin
      flags_d.c = add_sum[WordW];
      flags_d.v = add_v;
    end
    if (set_c) begin
      flags_d.c = c_new;
    end
  end

  always_comb begin
    res_d.result        = wr ? r : '0;
    res_d.writes_result = wr;
    res_d.flag_negative = flags_d.n;
    res_d.flag_zero     = flags_d.z;
    res_d.flag_carry    = flags_d.c;
    res_d.flag_overflow = flags_d.v;
    res_d.next_pc       = pc_d;
    res_d.link_value    = lr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
      flags_q   <= '0;
      pc_q      <= '0;
      lr_q      <= '0;
    end else if (advance) begin
      res_vld_q <= item_vld_q;
      if (item_vld_q) begin
        flags_q <= flags_d;
        pc_q    <= pc_d;
        lr_q    <= lr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid   = res_vld_q;
  assign out_o.payload = res_q;

endmodule

>>> tb/tafbu_checker.sv
`timescale 1ns / 100ps
// result checker for the thumb execute unit: predicts each result beat and compares it
// watches both channels; depends on tafbu_pkg and the interfaces in tafbu_if.sv
module tafbu_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tafbu_in_if  instr_mon,
  tafbu_out_if retire_mon,
  output int   errors_o,
  output int   pending_o
);
  import tafbu_pkg::*;

  nzcv_t            arch_flags;
  logic [WordW-1:0] arch_pc;
  logic [WordW-1:0] arch_lr;
  out_item_t        retire_q[$];
  int               mismatch_cnt = 0;

  function automatic void set_nz(input logic [WordW-1:0] r);
    arch_flags.n = r[WordW-1];
    arch_flags.z = (r == '0);
  endfunction

  // x + y + cin with full nzcv update
  function automatic logic [WordW-1:0] add_with_flags(input logic [WordW-1:0] x,
                                                      input logic [WordW-1:0] y,
                                                      input logic cin);
    logic [WordW:0]   wide;
    logic [WordW-1:0] sum;
    wide = {1'b0, x} + {1'b0, y} + {{WordW{1'b0}}, cin};
    sum  = wide[WordW-1:0];
    set_nz(sum);
    arch_flags.c = wide[WordW];
    arch_flags.v = ~(x[WordW-1] ^ y[WordW-1]) & (x[WordW-1] ^ sum[WordW-1]);
    return sum;
  endfunction

  function automatic logic cond_holds(input logic [3:0] cond);
    case (cond_e'(cond))
      COND_EQ: return arch_flags.z;
      COND_NE: return !arch_flags.z;
      COND_CS: return arch_flags.c;
      COND_CC: return !arch_flags.c;
      COND_MI: return arch_flags.n;
      COND_PL: return !arch_flags.n;
      COND_VS: return arch_flags.v;
      COND_VC: return !arch_flags.v;
      COND_HI: return arch_flags.c && !arch_flags.z;
      COND_LS: return !arch_flags.c || arch_flags.z;
      COND_GE: return arch_flags.n == arch_flags.v;
      COND_LT: return arch_flags.n != arch_flags.v;
      COND_GT: return !arch_flags.z && (arch_flags.n == arch_flags.v);
      COND_LE: return arch_flags.z || (arch_flags.n != arch_flags.v);
      COND_AL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic out_item_t exec_instr(input in_item_t ins);
    logic [WordW-1:0] a, b, r, off, step;
    logic [AmtW-1:0]  amt;
    logic [4:0]       rot;
    logic             wr;
    out_item_t        o;
    a    = ins.operand_a;
    b    = ins.operand_b;
    amt  = b[AmtW-1:0];
    rot  = amt[4:0];
    off  = {{(WordW-OffsetW){ins.branch_offset[OffsetW-1]}}, ins.branch_offset};
    r    = '0;
    wr   = 1'b1;
    step = PcStep;
    case (action_e'(ins.action))
      ACT_ADC: r = add_with_flags(a, b, arch_flags.c);
      ACT_ADD: r = add_with_flags(a, b, 1'b0);
      ACT_EOR: begin r = a ^ b; set_nz(r); end
      ACT_ORR: begin r = a | b; set_nz(r); end
      ACT_AND: begin r = a & b; set_nz(r); end
      ACT_MOV: begin r = a; set_nz(r); end
      ACT_SUB: r = add_with_flags(a, ~b, 1'b1);
      ACT_CMP: begin
        r  = add_with_flags(a, ~b, 1'b1);
        wr = 1'b0;
      end
      ACT_CMN: begin
        r  = add_with_flags(a, b, 1'b0);
        wr = 1'b0;
      end
      ACT_MUL: begin r = a * b; set_nz(r); end
      ACT_TST: begin set_nz(a & b); wr = 1'b0; end
      ACT_LSL: begin
        if (amt == 0) r = a;
        else if (amt < 32) begin
          arch_flags.c = a[32 - amt];
          r = a << amt;
        end else if (amt == 32) begin
          arch_flags.c = a[0];
          r = '0;
        end else begin
          arch_flags.c = 1'b0;
          r = '0;
        end
        set_nz(r);
      end
      ACT_LSR: begin
        if (amt == 0) r = a;
        else if (amt < 32) begin
          arch_flags.c = a[amt - 1];
          r = a >> amt;
        end else if (amt == 32) begin
          arch_flags.c = a[31];
          r = '0;
        end else begin
          arch_flags.c = 1'b0;
          r = '0;
        end
        set_nz(r);
      end
      ACT_ROR: begin
        if (amt == 0) r = a;
        else if (rot == 0) begin
          r = a;
          arch_flags.c = a[31];
        end else begin
          r = (a >> rot) | (a << (32 - rot));
          arch_flags.c = r[31];
        end
        set_nz(r);
      end
      ACT_ASR: begin
        if (amt == 0) r = a;
        else if (amt < 32) begin
          arch_flags.c = a[amt - 1];
          r = $signed(a) >>> amt;
        end else begin
          r = {WordW{a[31]}};
          arch_flags.c = a[31];
        end
        set_nz(r);
      end
      ACT_REV: r = {a[7:0], a[15:8], a[23:16], a[31:24]};
      ACT_BIC: begin r = a & ~b; set_nz(r); end
      ACT_MVN: begin r = ~a; set_nz(r); end
      ACT_NEG: r = add_with_flags('0, ~a, 1'b1);
      ACT_SBC: r = add_with_flags(a, ~b, arch_flags.c);
      ACT_NOP: wr = 1'b0;
      ACT_B: begin
        wr = 1'b0;
        if (cond_holds(ins.branch_cond)) step = off << 1;
      end
      ACT_BL: begin
        wr      = 1'b0;
        arch_lr = arch_pc + PcStep;
        step    = off << 1;
      end
      ACT_BX: begin
        wr   = 1'b0;
        step = a - arch_pc;
      end
      default: wr = 1'b0;
    endcase
    arch_pc = arch_pc + step;
    o.result        = wr ? r : '0;
    o.writes_result = wr;
    o.flag_negative = arch_flags.n;
    o.flag_zero     = arch_flags.z;
    o.flag_carry    = arch_flags.c;
    o.flag_overflow = arch_flags.v;
    o.next_pc       = arch_pc;
    o.link_value    = arch_lr;
    return o;
  endfunction

  function automatic int field_bad(input string name, input logic [WordW-1:0] want,
                                   input logic [WordW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_retire(input out_item_t got);
    out_item_t want;
    if (retire_q.size() == 0) begin
      $error("result beat with no instruction outstanding: %p", got);
      mismatch_cnt++;
      return;
    end
    want = retire_q.pop_front();
    mismatch_cnt += field_bad("result", want.result, got.result);
    mismatch_cnt += field_bad("writes_result", WordW'(want.writes_result),
                              WordW'(got.writes_result));
    mismatch_cnt += field_bad("flag_negative", WordW'(want.flag_negative),
                              WordW'(got.flag_negative));
    mismatch_cnt += field_bad("flag_zero", WordW'(want.flag_zero), WordW'(got.flag_zero));
    mismatch_cnt += field_bad("flag_carry", WordW'(want.flag_carry), WordW'(got.flag_carry));
    mismatch_cnt += field_bad("flag_overflow", WordW'(want.flag_overflow),
                              WordW'(got.flag_overflow));
    mismatch_cnt += field_bad("next_pc", want.next_pc, got.next_pc);
    mismatch_cnt += field_bad("link_value", want.link_value, got.link_value);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_flags = '0;
      arch_pc    = '0;
      arch_lr    = '0;
      retire_q.delete();
      pending_o <= 0;
      errors_o  <= mismatch_cnt;
    end else begin
      if (instr_mon.valid && instr_mon.ready) retire_q.push_back(exec_instr(instr_mon.payload));
      if (retire_mon.valid && retire_mon.ready) check_retire(retire_mon.payload);
      pending_o <= retire_q.size();
      errors_o  <= mismatch_cnt;
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// testbench top for the thumb execute unit: clock, reset, instruction beats and stalls
// depends on tafbu_pkg, tafbu_if.sv, thumb_alu_flags_branch_unit and tafbu_checker
module tb;
  import tafbu_pkg::*;

  logic clk_i      = 1'b0;
  logic rst_ni     = 1'b0;
  logic calm       = 1'b0;
  int   stall_left = 0;
  int   fail_count;
  int   outstanding;

  tafbu_in_if  instr_if ();
  tafbu_out_if retire_if ();

  thumb_alu_flags_branch_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (instr_if),
    .out_o  (retire_if)
  );

  tafbu_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .instr_mon  (instr_if),
    .retire_mon (retire_if),
    .errors_o   (fail_count),
    .pending_o  (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t mk_instr(input logic [4:0] act, input logic [WordW-1:0] a,
                                        input logic [WordW-1:0] b, input logic [3:0] cond,
                                        input logic [OffsetW-1:0] off);
    in_item_t ins;
    ins.action        = act;
    ins.operand_a     = a;
    ins.operand_b     = b;
    ins.branch_cond   = cond;
    ins.branch_offset = off;
    return ins;
  endfunction

  function automatic in_item_t rand_instr();
    in_item_t ins;
    // unused action codes now and then
    if ($urandom_range(0, 99) < 6) ins.action = 5'($urandom_range(24, 31));
    else ins.action = 5'($urandom_range(ACT_ADC, ACT_BX));
    ins.operand_a   = rand_word();
    ins.operand_b   = rand_word();
    ins.branch_cond = 4'($urandom_range(0, 15));
    if (ins.action >= ACT_LSL && ins.action <= ACT_ASR && $urandom_range(0, 3) != 0)
      ins.operand_b[AmtW-1:0] = 8'($urandom_range(0, 40));
    if ($urandom_range(0, 3) == 0) ins.branch_offset = OffsetW'($urandom);
    else ins.branch_offset = OffsetW'($urandom_range(0, 64)) - OffsetW'(32);
    return ins;
  endfunction

  task automatic send_instr(input in_item_t ins);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    if (gap > 0) begin
      instr_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    instr_if.valid   <= 1'b1;
    instr_if.payload <= ins;
    @(posedge clk_i);
    while (!instr_if.ready) @(posedge clk_i);
  endtask

  // hold the sender off until every result beat is back
  task automatic wait_drained();
    instr_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      retire_if.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      retire_if.ready <= 1'b0;
      stall_left      <= idle_len() - 1;
    end else begin
      retire_if.ready <= 1'b1;
    end
  end

  initial begin
    in_item_t directed[$];
    instr_if.valid   <= 1'b0;
    instr_if.payload <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(mk_instr(ACT_ADD, 32'hffff_ffff, 32'h1, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_ADC, 32'h7fff_ffff, 32'h0, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_SUB, 32'h5, 32'h5, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_CMP, 32'h0, 32'h1, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_CMN, 32'h8000_0000, 32'h8000_0000, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_SBC, 32'h0, 32'h0, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_NEG, 32'h0, 32'h0, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_NEG, 32'h8000_0000, 32'h0, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_MUL, 32'hffff_ffff, 32'hffff_ffff, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_TST, 32'hf0, 32'h0f, COND_EQ, '0));
    // shift corners: zero amount, exactly 32, beyond 32
    directed.push_back(mk_instr(ACT_LSL, 32'h8000_0001, 32'hffff_ff00, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_LSL, 32'h8000_0001, 32'd32, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_LSR, 32'h8000_0000, 32'd32, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_LSR, 32'hffff_ffff, 32'hffff_ff28, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_ASR, 32'h8000_0000, 32'd40, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_ROR, 32'h8000_0001, 32'd32, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_EOR, 32'hffff_ffff, 32'h0f0f_0f0f, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_ORR, 32'h0, 32'h0, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_AND, 32'hffff_ffff, 32'h8000_0000, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_MOV, 32'h0, 32'hffff_ffff, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_BIC, 32'hffff_ffff, 32'h7fff_ffff, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_MVN, 32'h0, 32'h0, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_REV, 32'h1234_5678, 32'h0, COND_EQ, '0));
    directed.push_back(mk_instr(ACT_NOP, 32'hffff_ffff, 32'hffff_ffff, COND_AL, 24'h7fffff));
    directed.push_back(mk_instr(5'd31, 32'hffff_ffff, 32'hffff_ffff, COND_AL, 24'hffffff));
    directed.push_back(mk_instr(ACT_B, 32'h0, 32'h0, 4'd15, 24'hffffff));
    directed.push_back(mk_instr(ACT_B, 32'h0, 32'h0, COND_AL, 24'h800000));
    directed.push_back(mk_instr(ACT_BL, 32'h0, 32'h0, COND_EQ, 24'h7fffff));
    directed.push_back(mk_instr(ACT_BX, 32'hffff_ffff, 32'h0, COND_EQ, '0));
    foreach (directed[j]) send_instr(directed[j]);
    wait_drained();

    for (int i = 0; i < 1000; i++) begin
      if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == 500) wait_drained();
      send_instr(rand_instr());
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
